@@ rtl/core/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the environmental sensor compensation core.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP    = 3'd0,
    CFG_PRESS_A = 3'd1,
    CFG_PRESS_B = 3'd2,
    CFG_PRESS_C = 3'd3,
    CFG_HUM_A   = 3'd4,
    CFG_HUM_B   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
  } hum_coef_t;

  localparam int unsigned DIV_W = 64;

  localparam logic [31:0] TFINE_P_OFS = 32'd128000;
  localparam logic [63:0] P_BASE      = 64'd1048576;
  localparam logic [63:0] P_SCALE     = 64'd3125;
  localparam logic [31:0] TFINE_H_OFS = 32'd76800;
  localparam logic [31:0] H_W_OFS     = 32'd2097152;
  localparam logic [31:0] H_MAX       = 32'd419430400;

  // pipeline depths
  localparam int unsigned LAT_TEMP  = 5;
  localparam int unsigned LAT_PRE   = 11;
  localparam int unsigned LAT_DIV   = DIV_W + 2;
  localparam int unsigned LAT_POST  = 4;
  localparam int unsigned LAT_HUM   = 7;
  localparam int unsigned LAT_TOTAL = LAT_PRE + LAT_DIV + LAT_POST;
  localparam int unsigned TEMP_DLY  = LAT_TOTAL - LAT_TEMP;
  localparam int unsigned HUM_DLY   = LAT_TOTAL - LAT_TEMP - LAT_HUM;

endpackage

`default_nettype wire

@@ rtl/core/esc_div.sv @@
// ----------------------------------------------------------------------------
// esc_div
// Pipelined 64-bit signed divider, truncating, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_div (
  input  wire logic                       clk_i,
  input  wire logic [esc_pkg::DIV_W-1:0]  num_i,
  input  wire logic [esc_pkg::DIV_W-1:0]  den_i,
  output logic      [esc_pkg::DIV_W-1:0]  quo_o,
  output logic                            zero_o
);
  import esc_pkg::*;

  logic [DIV_W-1:0] rem_q [DIV_W+1];
  logic [DIV_W-1:0] dq_q  [DIV_W+1];
  logic [DIV_W-1:0] dv_q  [DIV_W+1];
  logic             neg_q [DIV_W+1];
  logic             zr_q  [DIV_W+1];

  logic [DIV_W-1:0] quo_q;
  logic             zero_q;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    dq_q[0]  <= num_i[DIV_W-1] ? (~num_i + 1'b1) : num_i;
    dv_q[0]  <= den_i[DIV_W-1] ? (~den_i + 1'b1) : den_i;
    neg_q[0] <= num_i[DIV_W-1] ^ den_i[DIV_W-1];
    zr_q[0]  <= (den_i == '0);
  end

  for (genvar i = 0; i < DIV_W; i++) begin : g_step
    logic [DIV_W-1:0] trial;
    logic             fits;
    assign trial = {rem_q[i][DIV_W-2:0], dq_q[i][DIV_W-1]};
    assign fits  = (trial >= dv_q[i]);
    always_ff @(posedge clk_i) begin
      rem_q[i+1] <= fits ? (trial - dv_q[i]) : trial;
      dq_q[i+1]  <= {dq_q[i][DIV_W-2:0], fits};
      dv_q[i+1]  <= dv_q[i];
      neg_q[i+1] <= neg_q[i];
      zr_q[i+1]  <= zr_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= neg_q[DIV_W] ? (~dq_q[DIV_W] + 1'b1) : dq_q[DIV_W];
    zero_q <= zr_q[DIV_W];
  end

  assign quo_o  = quo_q;
  assign zero_o = zero_q;

endmodule

`default_nettype wire

@@ rtl/core/esc_hum.sv @@
// ----------------------------------------------------------------------------
// esc_hum
// Seven-stage humidity compensation pipeline, 32-bit wrap, clamped result.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_hum (
  input  wire logic                      clk_i,
  input  wire logic [31:0]               hv_i,
  input  wire logic [15:0]               adch_i,
  input  wire esc_pkg::hum_coef_t        coef_i,
  output logic      [16:0]               hum_o
);
  import esc_pkg::*;

  logic [31:0] h2w, h4w, h5w, h6w;
  assign h2w = {{16{coef_i.h2[15]}}, coef_i.h2};
  assign h4w = {{20{coef_i.h4[11]}}, coef_i.h4};
  assign h5w = {{20{coef_i.h5[11]}}, coef_i.h5};
  assign h6w = {{24{coef_i.h6[7]}}, coef_i.h6};

  logic [31:0] hap_q, ym_q, zm_q;
  logic [31:0] ha_q, yz_q;
  logic [31:0] ha3_q, wh_q;
  logic [31:0] v_q, v5_q, ss_q, v6_q, tt_q;
  logic [16:0] hum_q;

  logic [31:0] ysh, zsh, wsh, hb, s, ssh, vv, vc;

  assign ysh = 32'($signed(ym_q) >>> 10);
  assign zsh = 32'($signed(zm_q) >>> 11) + 32'd32768;
  assign wsh = 32'($signed(yz_q) >>> 10) + H_W_OFS;
  assign hb  = 32'($signed(wh_q) >>> 14);
  assign s   = 32'($signed(v_q) >>> 15);
  assign ssh = 32'($signed(ss_q) >>> 7);
  assign vv  = v6_q - 32'($signed(tt_q) >>> 4);

  always_comb begin
    vc = vv;
    if (vv[31]) begin
      vc = '0;
    end else if (vv > H_MAX) begin
      vc = H_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    hap_q <= {2'd0, adch_i, 14'd0} - (h4w << 20) - h5w * hv_i + 32'd16384;
    ym_q  <= hv_i * h6w;
    zm_q  <= hv_i * {24'd0, coef_i.h3};
    ha_q  <= 32'($signed(hap_q) >>> 15);
    yz_q  <= ysh * zsh;
    ha3_q <= ha_q;
    wh_q  <= wsh * h2w + 32'd8192;
    v_q   <= ha3_q * hb;
    v5_q  <= v_q;
    ss_q  <= s * s;
    v6_q  <= v5_q;
    tt_q  <= ssh * {24'd0, coef_i.h1};
    hum_q <= vc[28:12];
  end

  assign hum_o = hum_q;

endmodule

`default_nettype wire

@@ rtl/core/env_sensor_compensation.sv @@
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of raw pressure, temperature and humidity samples.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   sample   | start_i / busy_o        | raw_pressure/temperature/humidity_i
//   result   | done_o (one-cycle)      | temperature/pressure/humidity_o
//   config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One sample enters every cycle; busy_o stays low.
// Most of each result's delay from its start lies in the 64-stage divider.
// Reset clears the valid pipeline and coefficients; data registers run free.
// Results are shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module env_sensor_compensation (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [19:0]                      raw_pressure_i,
  input  wire logic [19:0]                      raw_temperature_i,
  input  wire logic [15:0]                      raw_humidity_i,
  output logic                                  done_o,
  output logic signed [31:0]                    temperature_o,
  output logic [31:0]                           pressure_o,
  output logic                                  pressure_invalid_o,
  output logic [16:0]                           humidity_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [esc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [esc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import esc_pkg::*;

  logic [47:0] tc_q, pa_q, pb_q, pc_q;
  logic [31:0] ha_q, hb_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      pc_q <= '0;
      ha_q <= '0;
      hb_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TEMP:    tc_q <= cfg_data_i;
        CFG_PRESS_A: pa_q <= cfg_data_i;
        CFG_PRESS_B: pb_q <= cfg_data_i;
        CFG_PRESS_C: pc_q <= cfg_data_i;
        CFG_HUM_A:   ha_q <= cfg_data_i[31:0];
        CFG_HUM_B:   hb_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // coefficients
  logic [15:0]        t1;
  logic [31:0]        t2w, t3w;
  logic signed [16:0] p1s;
  logic signed [15:0] p2s, p3s, p5s, p6s, p8s, p9s;
  logic signed [63:0] p4w, p7w;
  hum_coef_t          hcoef;

  assign t1  = tc_q[15:0];
  assign t2w = {{16{tc_q[31]}}, tc_q[31:16]};
  assign t3w = {{16{tc_q[47]}}, tc_q[47:32]};
  assign p1s = {1'b0, pa_q[15:0]};
  assign p2s = pa_q[31:16];
  assign p3s = pa_q[47:32];
  assign p4w = 64'(signed'(pb_q[15:0]));
  assign p5s = pb_q[31:16];
  assign p6s = pb_q[47:32];
  assign p7w = 64'(signed'(pc_q[15:0]));
  assign p8s = pc_q[31:16];
  assign p9s = pc_q[47:32];
  assign hcoef.h1 = ha_q[7:0];
  assign hcoef.h2 = ha_q[23:8];
  assign hcoef.h3 = ha_q[31:24];
  assign hcoef.h4 = hb_q[11:0];
  assign hcoef.h5 = hb_q[23:12];
  assign hcoef.h6 = hb_q[31:24];

  // valid bits
  logic [LAT_TOTAL:1] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT_TOTAL-1:1], start_i && !busy_o};
    end
  end

  // raw sample carry
  logic [19:0] adp_q [1:9];
  logic [15:0] adh_q [1:5];
  always_ff @(posedge clk_i) begin
    adp_q[1] <= raw_pressure_i;
    adh_q[1] <= raw_humidity_i;
    for (int i = 2; i <= 9; i++) adp_q[i] <= adp_q[i-1];
    for (int i = 2; i <= 5; i++) adh_q[i] <= adh_q[i-1];
  end

  // temperature
  logic [31:0] a_q, d_q, m1_q, dd_q, tv1_q, m2_q, tfine_q, hv_q;
  logic [31:0] dd_sh, m2_sh, tw;
  logic signed [32:0] pv1_q;

  assign dd_sh = 32'($signed(dd_q) >>> 12);
  assign m2_sh = 32'($signed(m2_q) >>> 14);
  assign tw    = tfine_q * 32'd5 + 32'd128;

  logic [31:0] tdly_q [TEMP_DLY+1];

  always_ff @(posedge clk_i) begin
    a_q     <= {15'd0, raw_temperature_i[19:3]} - {15'd0, t1, 1'b0};
    d_q     <= {16'd0, raw_temperature_i[19:4]} - {16'd0, t1};
    m1_q    <= a_q * t2w;
    dd_q    <= d_q * d_q;
    tv1_q   <= 32'($signed(m1_q) >>> 11);
    m2_q    <= dd_sh * t3w;
    tfine_q <= tv1_q + m2_sh;
    tdly_q[0] <= 32'($signed(tw) >>> 8);
    pv1_q   <= $signed({tfine_q[31], tfine_q}) - $signed({1'b0, TFINE_P_OFS});
    hv_q    <= tfine_q - TFINE_H_OFS;
    for (int i = 1; i <= TEMP_DLY; i++) tdly_q[i] <= tdly_q[i-1];
  end

  // pressure, ahead of the division
  logic signed [63:0] sq_full;
  logic signed [63:0] sq_q, v1p5_q, v1p2_q, v1p5b_q, v1p2b_q, a6_q, a3_q;
  logic signed [63:0] v2_q, v1b_q, v2b_q, prod_q, den_q, den11_q;
  logic [63:0]        num_q, num11_q, pd;

  assign sq_full = pv1_q * pv1_q;
  assign pd      = P_BASE - {44'd0, adp_q[9]};

  always_ff @(posedge clk_i) begin
    sq_q    <= sq_full;
    v1p5_q  <= pv1_q * p5s;
    v1p2_q  <= pv1_q * p2s;
    a6_q    <= sq_q * p6s;
    a3_q    <= sq_q * p3s;
    v1p5b_q <= v1p5_q;
    v1p2b_q <= v1p2_q;
    v2_q    <= a6_q + (v1p5b_q <<< 17) + (p4w <<< 35);
    v1b_q   <= (a3_q >>> 8) + (v1p2b_q <<< 12);
    prod_q  <= (64'sh0000_8000_0000_0000 + v1b_q) * p1s;
    v2b_q   <= v2_q;
    den_q   <= prod_q >>> 33;
    num_q   <= (pd << 31) - v2b_q;
    num11_q <= num_q * P_SCALE;
    den11_q <= den_q;
  end

  logic [63:0] quo;
  logic        dzero;

  esc_div u_div (
    .clk_i  (clk_i),
    .num_i  (num11_q),
    .den_i  (den11_q),
    .quo_o  (quo),
    .zero_o (dzero)
  );

  // pressure, after the division
  logic signed [63:0] q78_q, q79_q, q80_q, p8q_q, v2c_q, v2c80_q, pp_q, t9_q;
  logic signed [63:0] ph, psum, pres;
  logic [63:0]        ll_q;
  logic [31:0]        cr_q, pres_q;
  logic               inv78_q, inv79_q, inv80_q, inv_q;

  assign ph   = $signed(quo) >>> 13;
  assign psum = q80_q + (t9_q >>> 25) + v2c80_q;
  assign pres = (psum >>> 8) + (p7w <<< 4);

  always_ff @(posedge clk_i) begin
    ll_q    <= {32'd0, ph[31:0]} * {32'd0, ph[31:0]};
    cr_q    <= ph[31:0] * ph[63:32];
    p8q_q   <= $signed(quo) * p8s;
    q78_q   <= quo;
    inv78_q <= dzero;
    pp_q    <= ll_q + {cr_q[30:0], 33'd0};
    v2c_q   <= p8q_q >>> 19;
    q79_q   <= q78_q;
    inv79_q <= inv78_q;
    t9_q    <= pp_q * p9s;
    v2c80_q <= v2c_q;
    q80_q   <= q79_q;
    inv80_q <= inv79_q;
    pres_q  <= inv80_q ? '0 : pres[31:0];
    inv_q   <= inv80_q;
  end

  // humidity
  logic [16:0] hum;
  logic [16:0] hdly_q [HUM_DLY];

  esc_hum u_hum (
    .clk_i  (clk_i),
    .hv_i   (hv_q),
    .adch_i (adh_q[5]),
    .coef_i (hcoef),
    .hum_o  (hum)
  );

  always_ff @(posedge clk_i) begin
    hdly_q[0] <= hum;
    for (int i = 1; i < HUM_DLY; i++) hdly_q[i] <= hdly_q[i-1];
  end

  assign done_o             = vld_q[LAT_TOTAL];
  assign temperature_o      = tdly_q[TEMP_DLY];
  assign pressure_o         = pres_q;
  assign pressure_invalid_o = inv_q;
  assign humidity_o         = hdly_q[HUM_DLY-1];

endmodule

`default_nettype wire

@@ rtl/core/esc_chk.sv @@
// ----------------------------------------------------------------------------
// esc_chk
// Port-level checks of the compensation core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [31:0] pressure_o,
  input wire logic        pressure_invalid_o,
  input wire logic [16:0] humidity_o
);
  import esc_pkg::*;

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT_TOTAL))
    else $error("result without matching transaction");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pressure_invalid_o) |-> (pressure_o == 32'd0))
    else $error("invalid pressure not forced to zero");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (humidity_o <= 17'd102400))
    else $error("humidity above full scale");

endmodule

bind env_sensor_compensation esc_chk u_esc_chk (.*);

`default_nettype wire

@@ verif/esc_checker.sv @@
// ----------------------------------------------------------------------------
// esc_checker
// Watches the sample, result and coefficient channels of the compensation
// core, predicts each result from its own copy of the coefficients and
// compares every result field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic                           busy_i,
  input  wire logic [19:0]                    raw_pressure_i,
  input  wire logic [19:0]                    raw_temperature_i,
  input  wire logic [15:0]                    raw_humidity_i,
  input  wire logic                           done_i,
  input  wire logic [31:0]                    temperature_i,
  input  wire logic [31:0]                    pressure_i,
  input  wire logic                           pressure_invalid_i,
  input  wire logic [16:0]                    humidity_i,
  input  wire logic                           cfg_valid_i,
  input  wire logic                           cfg_ready_i,
  input  wire logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [esc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                                  pending_o,
  output int                                  fail_count_o
);

  import esc_pkg::*;

  typedef struct packed {
    logic [31:0] temperature;
    logic [31:0] pressure;
    logic        pressure_invalid;
    logic [16:0] humidity;
  } comp_result_t;

  logic [47:0] temp_cf, press_cf_a, press_cf_b, press_cf_c;
  logic [31:0] hum_cf_a, hum_cf_b;
  comp_result_t compensated_q[$];
  int fails;

  assign fail_count_o = fails;

  function automatic logic [31:0] sra32(logic [31:0] x, int s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] x, int s);
    return 64'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic logic [63:0] quotient64(logic [63:0] n, logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q  = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic comp_result_t compensate(logic [19:0] rp, logic [19:0] rt,
                                              logic [15:0] rh);
    logic [31:0] t1, t2, t3, a, d, tv1, tv2, tf;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, ph;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, ha, y, z, w, hb, s;
    comp_result_t r;
    t1  = {16'b0, temp_cf[15:0]};
    t2  = {{16{temp_cf[31]}}, temp_cf[31:16]};
    t3  = {{16{temp_cf[47]}}, temp_cf[47:32]};
    a   = (32'(rt) >> 3) - (t1 << 1);
    d   = (32'(rt) >> 4) - t1;
    tv1 = sra32(a * t2, 11);
    tv2 = sra32(sra32(d * d, 12) * t3, 14);
    tf  = tv1 + tv2;
    r.temperature = sra32(tf * 32'd5 + 32'd128, 8);

    p1 = {48'b0, press_cf_a[15:0]};
    p2 = sx16(press_cf_a[31:16]);
    p3 = sx16(press_cf_a[47:32]);
    p4 = sx16(press_cf_b[15:0]);
    p5 = sx16(press_cf_b[31:16]);
    p6 = sx16(press_cf_b[47:32]);
    p7 = sx16(press_cf_c[15:0]);
    p8 = sx16(press_cf_c[31:16]);
    p9 = sx16(press_cf_c[47:32]);
    v1 = {{32{tf[31]}}, tf} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
    if (v1 == 64'd0) begin
      r.pressure_invalid = 1'b1;
      r.pressure = 32'd0;
    end else begin
      r.pressure_invalid = 1'b0;
      p  = 64'd1048576 - 64'(rp);
      p  = quotient64(((p << 31) - v2) * 64'd3125, v1);
      ph = sra64(p, 13);
      v1 = sra64(p9 * ph * ph, 25);
      v2 = sra64(p8 * p, 19);
      p  = sra64(p + v1 + v2, 8) + (p7 << 4);
      r.pressure = p[31:0];
    end

    h1 = {24'b0, hum_cf_a[7:0]};
    h2 = {{16{hum_cf_a[23]}}, hum_cf_a[23:8]};
    h3 = {24'b0, hum_cf_a[31:24]};
    h4 = {{20{hum_cf_b[11]}}, hum_cf_b[11:0]};
    h5 = {{20{hum_cf_b[23]}}, hum_cf_b[23:12]};
    h6 = {{24{hum_cf_b[31]}}, hum_cf_b[31:24]};
    v  = tf - 32'd76800;
    ha = sra32((32'(rh) << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
    y  = sra32(v * h6, 10);
    z  = sra32(v * h3, 11) + 32'd32768;
    w  = sra32(y * z, 10) + 32'd2097152;
    hb = sra32(w * h2 + 32'd8192, 14);
    v  = ha * hb;
    s  = sra32(v, 15);
    v  = v - sra32(sra32(s * s, 7) * h1, 4);
    if (v[31]) v = 32'd0;
    if (v > 32'd419430400) v = 32'd419430400;
    r.humidity = 17'(v >> 12);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    comp_result_t want;
    if (!rst_ni) begin
      temp_cf    <= '0;
      press_cf_a <= '0;
      press_cf_b <= '0;
      press_cf_c <= '0;
      hum_cf_a   <= '0;
      hum_cf_b   <= '0;
      compensated_q.delete();
      pending_o  <= 0;
      fails      = 0;
    end else begin
      if (start_i && !busy_i) begin
        compensated_q.push_back(compensate(raw_pressure_i, raw_temperature_i,
                                           raw_humidity_i));
      end
      if (done_i) begin
        if (compensated_q.size() == 0) begin
          report("unexpected transaction", 32'd0, 32'd0);
        end else begin
          want = compensated_q.pop_front();
          if (temperature_i !== want.temperature)
            report("temperature", temperature_i, want.temperature);
          if (pressure_i !== want.pressure)
            report("pressure", pressure_i, want.pressure);
          if (pressure_invalid_i !== want.pressure_invalid)
            report("pressure_invalid", 32'(pressure_invalid_i),
                   32'(want.pressure_invalid));
          if (humidity_i !== want.humidity)
            report("humidity", 32'(humidity_i), 32'(want.humidity));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TEMP:    temp_cf    <= cfg_data_i;
          CFG_PRESS_A: press_cf_a <= cfg_data_i;
          CFG_PRESS_B: press_cf_b <= cfg_data_i;
          CFG_PRESS_C: press_cf_c <= cfg_data_i;
          CFG_HUM_A:   hum_cf_a   <= cfg_data_i[31:0];
          CFG_HUM_B:   hum_cf_b   <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      pending_o <= compensated_q.size();
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_env_sensor_compensation.sv @@
// ----------------------------------------------------------------------------
// tb_env_sensor_compensation
// Drives raw sample triples and coefficient sets into the compensation core:
// a directed part with extreme readings and coefficients, then random phases
// with realistic and fully random coefficients under varying sender gaps.
// Checking is done by esc_checker beside the core.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_env_sensor_compensation;

  import esc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
  localparam int                   CYCLE_LIMIT = 2000000;

  logic clk_i, rst_ni;
  logic start_i, busy_o;
  logic [19:0] raw_pressure_i, raw_temperature_i;
  logic [15:0] raw_humidity_i;
  logic done_o;
  logic signed [31:0] temperature_o;
  logic [31:0] pressure_o;
  logic pressure_invalid_o;
  logic [16:0] humidity_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int pending, fail_count, cycles, idle_pct;

  env_sensor_compensation u_top (.*);

  esc_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o),
    .raw_pressure_i, .raw_temperature_i, .raw_humidity_i,
    .done_i(done_o), .temperature_i(temperature_o), .pressure_i(pressure_o),
    .pressure_invalid_i(pressure_invalid_o), .humidity_i(humidity_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL env_sensor_compensation");
      $finish;
    end
  end

  task automatic send_sample(logic [19:0] p, logic [19:0] t, logic [15:0] h);
    start_i           <= 1'b1;
    raw_pressure_i    <= p;
    raw_temperature_i <= t;
    raw_humidity_i    <= h;
    do @(posedge clk_i); while (busy_o);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LAT_TOTAL + 20) @(posedge clk_i);
  endtask

  task automatic write_coeffs(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_typical(bit jitter);
    logic [15:0] j;
    j = jitter ? 16'($urandom_range(200)) - 16'd100 : 16'd0;
    write_coeffs(CFG_TEMP,    {16'hFC18 + j, 16'd26435, 16'd27504 + j});
    write_coeffs(CFG_PRESS_A, {16'd3024, 16'hD843 + j, 16'd36477 + j});
    write_coeffs(CFG_PRESS_B, {16'hFFF9, 16'd140 + j, 16'd2855});
    write_coeffs(CFG_PRESS_C, {16'd6000 + j, 16'hC6F8, 16'd15500});
    write_coeffs(CFG_HUM_A,   {16'($urandom), 8'd0, 16'd362 + j, 8'd75});
    write_coeffs(CFG_HUM_B,   {16'($urandom), 8'd30, 12'd50, 12'd313});
  endtask

  task automatic load_random();
    write_coeffs(CFG_TEMP,    48'({$urandom, $urandom}));
    write_coeffs(CFG_PRESS_A, 48'({$urandom, $urandom}));
    write_coeffs(CFG_PRESS_B, 48'({$urandom, $urandom}));
    write_coeffs(CFG_PRESS_C, 48'({$urandom, $urandom}));
    write_coeffs(CFG_HUM_A,   48'({$urandom, $urandom}));
    write_coeffs(CFG_HUM_B,   48'({$urandom, $urandom}));
  endtask

  task automatic load_all(logic [CFG_DATA_W-1:0] val);
    write_coeffs(CFG_TEMP, val);
    write_coeffs(CFG_PRESS_A, val);
    write_coeffs(CFG_PRESS_B, val);
    write_coeffs(CFG_PRESS_C, val);
    write_coeffs(CFG_HUM_A, val);
    write_coeffs(CFG_HUM_B, val);
  endtask

  task automatic random_samples(int n, bit typical);
    repeat (n) begin
      if (typical && $urandom_range(3) != 0)
        send_sample(20'd415148 + 20'($urandom_range(80000)) - 20'd40000,
                    20'd519888 + 20'($urandom_range(60000)) - 20'd30000,
                    16'($urandom_range(50000, 15000)));
      else
        send_sample(20'($urandom), 20'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    start_i = 1'b0; raw_pressure_i = '0; raw_temperature_i = '0; raw_humidity_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    cycles = 0; idle_pct = 0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients: zero divisor
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    drain();
    load_typical(1'b0);
    send_sample(20'd415148, 20'd519888, 16'd30000);
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'd0, 20'hFFFFF, 16'd0);
    send_sample(20'hFFFFF, 20'd0, 16'hFFFF);
    drain();
    // P1 of zero forces a zero divisor
    write_coeffs(CFG_PRESS_A, {16'd3024, 16'hD843, 16'd0});
    write_coeffs(CFG_UNUSED, '1);
    send_sample(20'd415148, 20'd519888, 16'd30000);
    send_sample(20'hFFFFF, 20'd0, 16'd0);
    drain();
    load_all('1);
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'h80000, 20'h80000, 16'h8000);
    drain();
    load_all({24'h7FFF7F, 24'hF7FFF7});
    send_sample(20'd0, 20'hFFFFF, 16'hFFFF);
    send_sample(20'hFFFFF, 20'd0, 16'd0);
    drain();
    write_coeffs(CFG_UNUSED + 3'd1, 48'({$urandom, $urandom}));

    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = (ph < 3) ? 17 : (ph < 6) ? 53 : 0;
      drain();
      if (ph % 3 == 2) load_random();
      else load_typical(1'b1);
      random_samples(190, ph % 3 != 2);
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS env_sensor_compensation");
    end else begin
      $display("FAIL env_sensor_compensation");
    end
    $finish;
  end

endmodule

`default_nettype wire
